FILE: src/btg_pkg.sv
// ----------------------------------------------------------------------------
// btg_pkg
// Types, constants and command codes shared by the buzzer tone generator.
// ----------------------------------------------------------------------------
package btg_pkg;

	localparam int unsigned TIMER_WIDTH_DEF = 16;
	localparam int unsigned CLK_W           = 26;
	localparam int unsigned FREQ_W          = 16;
	localparam int unsigned DUR_W           = 13;
	localparam int unsigned MS_W            = 16;
	localparam int unsigned RELOAD_OUT_W    = 16;

	localparam logic [CLK_W-1:0] CLOCK_HZ_RST = CLK_W'(11059200);

	// dividend is clock_hz / 4, so the quotient is clock_hz / (4 * freq)
	localparam int unsigned DIV_QW = CLK_W - 2;
	localparam int unsigned DIV_CW = $clog2(DIV_QW);

	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_MS    = 2'd1;
	localparam logic [1:0] CMD_CLK   = 2'd2;

	typedef struct packed {
		logic [1:0]       command;
		logic [FREQ_W-1:0] freq;
		logic [DUR_W-1:0]  duration_10ms;
	} btg_in_t;

	typedef struct packed {
		logic                    pin_level;
		logic                    busy_res;
		logic [RELOAD_OUT_W-1:0] reload_value;
	} btg_out_t;

	typedef struct packed {
		logic stop;
		logic start;
		logic ms_tick;
		logic clk_tick;
		logic div_step;
		logic load;
	} ctl_cmd_t;

	typedef struct packed {
		logic args_zero;
		logic div_last;
	} ctl_stat_t;

	typedef enum logic [1:0] {
		ST_READY,
		ST_DIV,
		ST_LOAD
	} ctl_state_t;

endpackage

FILE: src/btg_datapath.sv
// ----------------------------------------------------------------------------
// btg_datapath
// Tone counter, duration timer, pin register and a radix-2 restoring divider
// for the reload value.
// ----------------------------------------------------------------------------
module btg_datapath import btg_pkg::*; #(
	parameter int unsigned TIMER_WIDTH = TIMER_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CLK_W-1:0] cfg_wdata,
	input  btg_in_t          req,
	input  ctl_cmd_t         cmd,
	output ctl_stat_t        stat,
	output btg_out_t         res
);

	localparam int unsigned XW = (TIMER_WIDTH > DIV_QW) ? TIMER_WIDTH : DIV_QW;

	logic [CLK_W-1:0]       clock_hz_q;
	logic [TIMER_WIDTH-1:0] reload_q;
	logic [TIMER_WIDTH-1:0] count_q;
	logic [MS_W-1:0]        remaining_q;
	logic                   busy_q;
	logic                   run_q;
	logic                   pin_q;

	logic [FREQ_W-1:0]      divisor_q;
	logic [FREQ_W-1:0]      div_rem_q;
	logic [DIV_QW-1:0]      div_quo_q;
	logic [DIV_CW-1:0]      div_cnt_q;

	logic [MS_W:0]          ms_full;
	logic [MS_W-1:0]        ms_sat;
	logic [FREQ_W:0]        trial;
	logic                   trial_ge;
	logic [FREQ_W:0]        trial_diff;
	logic [XW-1:0]          quo_neg;
	logic [TIMER_WIDTH-1:0] reload_next;

	// duration * 10 as two shifts, saturating at the 16-bit limit
	assign ms_full = ({(MS_W+1-DUR_W)'(0), req.duration_10ms} << 3)
	               + ({(MS_W+1-DUR_W)'(0), req.duration_10ms} << 1);
	assign ms_sat  = ms_full[MS_W] ? {MS_W{1'b1}} : ms_full[MS_W-1:0];

	assign trial      = {div_rem_q, div_quo_q[DIV_QW-1]};
	assign trial_ge   = trial >= {1'b0, divisor_q};
	assign trial_diff = trial - {1'b0, divisor_q};

	// 2^W - quotient, modulo 2^W
	assign quo_neg     = XW'(0) - XW'(div_quo_q);
	assign reload_next = quo_neg[TIMER_WIDTH-1:0];

	assign stat.args_zero = (req.freq == '0) || (req.duration_10ms == '0);
	assign stat.div_last  = div_cnt_q == DIV_CW'(DIV_QW - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q <= CLOCK_HZ_RST;
		end else if (cfg_we) begin
			clock_hz_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			remaining_q <= '0;
			busy_q      <= 1'b0;
			run_q       <= 1'b0;
			pin_q       <= 1'b0;
			div_cnt_q   <= '0;
		end else begin
			if (cmd.stop) begin
				run_q  <= 1'b0;
				busy_q <= 1'b0;
			end else if (cmd.start) begin
				remaining_q <= ms_sat;
				busy_q      <= 1'b1;
				run_q       <= 1'b1;
				div_cnt_q   <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + DIV_CW'(1);
			end else if (cmd.load) begin
				count_q <= reload_next;
			end else if (cmd.ms_tick) begin
				if (busy_q && remaining_q != '0) begin
					remaining_q <= remaining_q - MS_W'(1);
					if (remaining_q == MS_W'(1)) begin
						run_q  <= 1'b0;
						busy_q <= 1'b0;
						pin_q  <= 1'b0;
					end
				end
			end else if (cmd.clk_tick) begin
				if (run_q) begin
					if (count_q == {TIMER_WIDTH{1'b1}}) begin
						count_q <= reload_q;
						pin_q   <= ~pin_q;
					end else begin
						count_q <= count_q + TIMER_WIDTH'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			divisor_q <= req.freq;
			div_rem_q <= '0;
			div_quo_q <= clock_hz_q[CLK_W-1:2];
		end else if (cmd.div_step) begin
			div_rem_q <= trial_ge ? trial_diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
			div_quo_q <= {div_quo_q[DIV_QW-2:0], trial_ge};
		end
		if (cmd.load) begin
			reload_q <= reload_next;
		end
	end

	assign res.pin_level    = pin_q;
	assign res.busy_res     = busy_q;
	assign res.reload_value = RELOAD_OUT_W'(reload_q);

endmodule

FILE: src/btg_ctrl.sv
// ----------------------------------------------------------------------------
// btg_ctrl
// Sequencer: decodes requests, runs the divider, owns the result valid flag.
// ----------------------------------------------------------------------------
module btg_ctrl import btg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  logic [1:0] command,
	output logic      res_valid,
	input  logic      res_stall,
	input  ctl_stat_t stat,
	output ctl_cmd_t  cmd
);

	ctl_state_t state_q, state_d;
	logic       out_valid_q, out_valid_d;
	logic       accept;
	logic       go_div;

	assign cmd_stall = (state_q != ST_READY) || (out_valid_q && res_stall);
	assign accept    = cmd_valid && !cmd_stall;
	assign res_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_READY;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		go_div  = 1'b0;
		unique case (state_q)
			ST_READY: begin
				if (accept) begin
					unique case (command)
						CMD_START: begin
							if (stat.args_zero) begin
								cmd.stop = 1'b1;
							end else begin
								cmd.start = 1'b1;
								go_div    = 1'b1;
								state_d   = ST_DIV;
							end
						end
						CMD_MS:  cmd.ms_tick  = 1'b1;
						CMD_CLK: cmd.clk_tick = 1'b1;
						default: ;
					endcase
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_d  = ST_READY;
			end
			default: state_d = ST_READY;
		endcase
		out_valid_d = (out_valid_q && res_stall) || (accept && !go_div) || cmd.load;
	end

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_READY) |-> cmd_stall)
		else $error("request taken while divider busy");

	a_div_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && command == CMD_START && !stat.args_zero) |=> (state_q == ST_DIV))
		else $error("start request did not enter divide");

	a_no_result_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> !out_valid_q)
		else $error("result shown during divide");

	a_load_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |=> out_valid_q)
		else $error("no result after reload load");

endmodule

FILE: src/buzzer_tone_generator_top.sv
// ----------------------------------------------------------------------------
// buzzer_tone_generator_top
// Square-wave buzzer driver. Millisecond and timer clock ticks may follow back
// to back. A start request with nonzero frequency and duration runs the 24
// iterations of the one-bit-per-cycle restoring divider that forms
// clock_hz / (4 * freq), loads the reload value, then gives the result. One
// result per request, giving pin level, busy flag and reload value after it;
// requests are held off while a result waits and is stalled. The user must
// ensure clock_hz is written only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module buzzer_tone_generator_top import btg_pkg::*; #(
	parameter int unsigned TIMER_WIDTH = TIMER_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	input  btg_in_t          cmd_data,
	output logic             res_valid,
	input  logic             res_stall,
	output btg_out_t         res_data,
	input  logic             cfg_we,
	input  logic [CLK_W-1:0] cfg_wdata
);

	ctl_cmd_t  ctl_cmd;
	ctl_stat_t ctl_stat;

	btg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.command   (cmd_data.command),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.stat      (ctl_stat),
		.cmd       (ctl_cmd)
	);

	btg_datapath #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (cmd_data),
		.cmd       (ctl_cmd),
		.stat      (ctl_stat),
		.res       (res_data)
	);

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for buzzer_tone_generator_top. A predictor tracks the
// reload value, counter, remaining time, busy/run flags and pin level. Every
// accepted request is predicted in order, and every result is checked field by
// field. The bench runs a directed sequence, then random tones under several
// oscillator settings and stall patterns, then a long receiver hold-off and a
// drain pause.
// ----------------------------------------------------------------------------
module tb import btg_pkg::*; ();

	localparam logic [1:0]  CMD_NONE  = 2'd3;
	localparam int unsigned RUN_LIMIT = 4_000_000;
	localparam logic [CLK_W-1:0] OSC_MIN   = CLK_W'(1_000_000);
	localparam logic [CLK_W-1:0] OSC_MAX   = CLK_W'(67_108_863);
	localparam logic [CLK_W-1:0] OSC_SLOW  = CLK_W'(262_139);

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cmd_valid;
	logic             cmd_stall;
	btg_in_t          cmd_data;
	logic             res_valid;
	logic             res_stall;
	btg_out_t         res_data;
	logic             cfg_we;
	logic [CLK_W-1:0] cfg_wdata;

	buzzer_tone_generator_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_data  (cmd_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #4 clk = ~clk;

	// predicted tone state
	logic [CLK_W-1:0] osc_hz;
	logic [15:0]      tone_reload;
	logic [15:0]      tone_count;
	logic [15:0]      tone_ms_left;
	logic             tone_busy;
	logic             tone_run;
	logic             tone_pin;

	btg_out_t awaited_states[$];

	int errors;
	int requests_sent;
	int results_seen;
	int tone_starts;
	int pin_toggles;
	int tone_expiries;
	int osc_writes;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_left;

	function automatic btg_out_t advance_tone(input btg_in_t r);
		logic [31:0] quot;
		logic [31:0] ms;
		btg_out_t    o;
		case (r.command)
			CMD_START: begin
				if (r.freq == '0 || r.duration_10ms == '0) begin
					tone_run  = 1'b0;
					tone_busy = 1'b0;
				end else begin
					quot         = 32'(osc_hz) / (32'(r.freq) << 2);
					ms           = 32'(r.duration_10ms) * 32'd10;
					tone_reload  = 16'(32'h1_0000 - quot);
					tone_count   = tone_reload;
					tone_ms_left = (ms > 32'hFFFF) ? 16'hFFFF : 16'(ms);
					tone_busy    = 1'b1;
					tone_run     = 1'b1;
					tone_starts++;
				end
			end
			CMD_MS: begin
				if (tone_busy && tone_ms_left != '0) begin
					tone_ms_left--;
					if (tone_ms_left == '0) begin
						tone_run  = 1'b0;
						tone_busy = 1'b0;
						tone_pin  = 1'b0;
						tone_expiries++;
					end
				end
			end
			CMD_CLK: begin
				if (tone_run) begin
					if (tone_count == 16'hFFFF) begin
						tone_count = tone_reload;
						tone_pin   = ~tone_pin;
						pin_toggles++;
					end else begin
						tone_count++;
					end
				end
			end
			default: begin
			end
		endcase
		o.pin_level    = tone_pin;
		o.busy_res     = tone_busy;
		o.reload_value = tone_reload;
		return o;
	endfunction

	task automatic check_field(input string name, input int unsigned want,
			input logic [31:0] got);
		if (got !== 32'(want)) begin
			errors++;
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : result_check
		btg_out_t want;
		if (arst_n === 1'b1 && res_valid === 1'b1 && res_stall === 1'b0) begin
			results_seen++;
			if (awaited_states.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none got %h", $time, res_data);
			end else begin
				want = awaited_states.pop_front();
				check_field("pin_level", 32'(want.pin_level), 32'(res_data.pin_level));
				check_field("busy_res", 32'(want.busy_res), 32'(res_data.busy_res));
				check_field("reload_value", 32'(want.reload_value),
					32'(res_data.reload_value));
			end
		end
		// long hold-off counted here; otherwise random stalls
		if (hold_left > 0) begin
			res_stall <= 1'b1;
			hold_left--;
		end else begin
			res_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
		end
	end

	task automatic send_request(input logic [1:0] cmd, input logic [FREQ_W-1:0] f,
			input logic [DUR_W-1:0] d);
		btg_in_t r;
		r.command       = cmd;
		r.freq          = f;
		r.duration_10ms = d;
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		cmd_valid <= 1'b1;
		cmd_data  <= r;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		awaited_states.push_back(advance_tone(r));
		requests_sent++;
	endtask

	task automatic send_tick(input logic [1:0] cmd);
		send_request(cmd, FREQ_W'($urandom_range(65535)), DUR_W'($urandom_range(8191)));
	endtask

	// always lets at least one edge pass, so valid never drops and rises in one step
	task automatic wait_drain();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (awaited_states.size() != 0);
	endtask

	task automatic set_osc(input logic [CLK_W-1:0] hz);
		wait_drain();
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= hz;
		@(posedge clk);
		cfg_we    <= 1'b0;
		osc_hz     = hz;
		osc_writes++;
	endtask

	task automatic test_directed();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_osc(OSC_MIN);
		// first request must write the reload value
		send_request(CMD_START, 16'hFFFF, 13'd1);
		send_request(CMD_NONE, 16'hFFFF, 13'h1FFF);
		repeat (3) send_request(CMD_CLK, '0, '0);
		// stop keeps the pin high
		send_request(CMD_START, '0, 13'd5);
		send_request(CMD_CLK, 16'hFFFF, 13'h1FFF);
		send_request(CMD_MS, 16'hFFFF, 13'h1FFF);
		// saturating duration, then replace the tone while playing
		send_request(CMD_START, 16'hFFFF, 13'h1FFF);
		send_request(CMD_START, 16'd1, 13'd1);
		send_request(CMD_START, 16'hFFFF, '0);
		send_request(CMD_START, 16'd40000, 13'd1);
		repeat (3) send_request(CMD_CLK, '0, '0);
		repeat (10) send_request(CMD_MS, '0, '0);
		// oscillator below 4*freq: quotient zero, reload zero
		set_osc(OSC_SLOW);
		send_request(CMD_START, 16'hFFFF, 13'd2);
		send_request(CMD_CLK, '0, '0);
		set_osc(OSC_MAX);
		send_request(CMD_START, 16'd1, 13'd3);
		send_request(CMD_START, 16'd0, 13'd0);
	endtask

	task automatic send_tone_start();
		logic [FREQ_W-1:0] f;
		logic [DUR_W-1:0]  d;
		int                pick;
		f    = ($urandom_range(99) < 75) ? FREQ_W'($urandom_range(65535, 4000))
		                                 : FREQ_W'($urandom_range(65535));
		pick = $urandom_range(99);
		if (pick < 70)
			d = DUR_W'($urandom_range(2, 1));
		else if (pick < 90)
			d = DUR_W'($urandom_range(8191, 3));
		else
			d = '0;
		send_request(CMD_START, f, d);
	endtask

	task automatic test_random_tones(input int n, input int s_pct, input int r_pct);
		int first;
		int len;
		int pick;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		first         = requests_sent;
		while (requests_sent - first < n) begin
			send_tone_start();
			len = $urandom_range(40, 6);
			for (int k = 0; k < len && requests_sent - first < n; k++) begin
				pick = $urandom_range(99);
				if (pick < 58)
					send_tick(CMD_CLK);
				else if (pick < 93)
					send_tick(CMD_MS);
				else
					send_tick(2'($urandom_range(3)));
			end
		end
	endtask

	// receiver holds off while the sender keeps offering, so the block backs up
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_tone_start();
		hold_left = 150;
		repeat (40) send_tick(($urandom_range(1)) ? CMD_CLK : CMD_MS);
	endtask

	task automatic test_drain_pause();
		send_idle_pct = 0;
		recv_idle_pct = 30;
		send_request(CMD_START, 16'd50000, 13'd1);
		repeat (5) send_tick(CMD_CLK);
		wait_drain();
		repeat (12) send_tick(CMD_MS);
		send_tick(CMD_CLK);
	endtask

	initial begin
		arst_n        = 1'b0;
		cmd_valid     = 1'b0;
		cmd_data      = '0;
		res_stall     = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = CLOCK_HZ_RST;
		osc_hz        = CLOCK_HZ_RST;
		tone_reload   = '0;
		tone_count    = '0;
		tone_ms_left  = '0;
		tone_busy     = 1'b0;
		tone_run      = 1'b0;
		tone_pin      = 1'b0;
		errors        = 0;
		requests_sent = 0;
		results_seen  = 0;
		tone_starts   = 0;
		pin_toggles   = 0;
		tone_expiries = 0;
		osc_writes    = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_left     = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		set_osc(OSC_MIN);
		test_random_tones(125, 28, 86);
		set_osc(OSC_MAX);
		test_random_tones(125, 86, 28);
		set_osc(CLOCK_HZ_RST);
		test_random_tones(125, 0, 0);
		set_osc(CLK_W'(2_500_000));
		test_backpressure();
		test_drain_pause();

		wait_drain();
		repeat (40) @(posedge clk);
		$display("Covered %0d requests and %0d results over %0d oscillator writes.",
			requests_sent, results_seen, osc_writes);
		$display("Tones started %0d, pin toggles %0d, timed-out tones %0d.",
			tone_starts, pin_toggles, tone_expiries);
		if (errors == 0 && awaited_states.size() == 0) begin
			$display("PASS buzzer_tone_generator_top");
		end else begin
			$display("%0d mismatches, %0d results outstanding", errors, awaited_states.size());
			$display("FAIL buzzer_tone_generator_top");
		end
		$finish;
	end

	initial begin
		#(RUN_LIMIT);
		$display("Timeout with %0d results outstanding", awaited_states.size());
		$display("FAIL buzzer_tone_generator_top");
		$finish;
	end

endmodule

FILE: files.f
src/btg_pkg.sv
src/btg_datapath.sv
src/btg_ctrl.sv
src/buzzer_tone_generator_top.sv
tb/tb.sv
